/* sv/ttrdt_pkg.sv */
// Shared types and constants of the triangle tile rasterizer with depth test.
// Holds datapath widths, request and register codes, the state encoding and structs.
// No dependencies.
`timescale 1ns / 1ps

package ttrdt_pkg;

  // Datapath widths (screen coords in 1/256 pixel, edge terms, divider)
  localparam int SW     = 22;   // screen coordinate, signed
  localparam int DFW    = 23;   // coordinate difference, signed
  localparam int EW     = 48;   // edge function / area, signed
  localparam int DIV_W  = 48;   // divider operand width
  localparam int QUO_W  = 17;   // quotient width (0.16 weights up to 1.0)
  localparam int PW     = 41;   // weight times reciprocal w
  localparam int SUMW   = 42;   // perspective sum
  localparam int ZPW    = 42;   // depth times weight, signed
  localparam int ZSW    = 44;   // depth sum, signed

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int NUM_SLOTS  = 3;

  localparam logic [QUO_W-1:0] ONE_Q16 = 17'd65536;

  // Request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_RASTER = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [23:0] z;
    logic [23:0]        rw;
  } vtx_t;

  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [23:0] frag_depth;
    logic [16:0] weight_a;
    logic [16:0] weight_b;
    logic [16:0] weight_c;
    logic        last_fragment;
  } frag_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MAP,
    ST_AREA_MUL,
    ST_AREA,
    ST_PIX,
    ST_EDGE,
    ST_BU_GO,
    ST_BU_WAIT,
    ST_BV_GO,
    ST_BV_WAIT,
    ST_SUM_MUL,
    ST_SUM,
    ST_WA_GO,
    ST_WA_WAIT,
    ST_WB_GO,
    ST_WB_WAIT,
    ST_WC_GO,
    ST_WC_WAIT,
    ST_Z_MUL,
    ST_Z,
    ST_CMP,
    ST_EMIT,
    ST_NEXT,
    ST_FLUSH
  } st_t;

endpackage

/* sv/ttrdt_in_if.sv */
// Request channel of the rasterizer: valid/ready handshake plus request fields.
// No dependencies.
`timescale 1ns / 1ps

interface ttrdt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [1:0]         vertex_slot;
  logic signed [15:0] ndc_x;
  logic signed [15:0] ndc_y;
  logic signed [23:0] ndc_z;
  logic [23:0]        recip_w;
  logic [5:0]         tile_col;
  logic [5:0]         tile_row;

  modport source (output valid, req_type, vertex_slot, ndc_x, ndc_y, ndc_z, recip_w,
                  tile_col, tile_row, input ready);
  modport sink (input valid, req_type, vertex_slot, ndc_x, ndc_y, ndc_z, recip_w,
                tile_col, tile_row, output ready);
endinterface

/* sv/ttrdt_out_if.sv */
// Fragment channel of the rasterizer: valid/ready handshake plus fragment fields.
// No dependencies.
`timescale 1ns / 1ps

interface ttrdt_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [23:0] frag_depth;
  logic [16:0] weight_a;
  logic [16:0] weight_b;
  logic [16:0] weight_c;
  logic        last_fragment;

  modport source (output valid, pixel_x, pixel_y, frag_depth, weight_a, weight_b,
                  weight_c, last_fragment, input ready);
  modport sink (input valid, pixel_x, pixel_y, frag_depth, weight_a, weight_b,
                weight_c, last_fragment, output ready);
endinterface

/* sv/ttrdt_div.sv */
// Restoring divider, one quotient bit per cycle, for barycentric and weight quotients.
// Dividend is {hi, lo} with hi < den; depends on ttrdt_pkg.
`timescale 1ns / 1ps

module ttrdt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ttrdt_pkg::DIV_W-1:0] hi,
  input  logic [ttrdt_pkg::QUO_W-1:0] lo,
  input  logic [ttrdt_pkg::DIV_W-1:0] den,
  output logic [ttrdt_pkg::QUO_W-1:0] quo,
  output ttrdt_pkg::div_sts_t         sts
);
  import ttrdt_pkg::*;

  localparam int CW = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] den_r;
  logic [QUO_W-1:0] lo_r;
  logic [QUO_W-1:0] quo_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   den_x;
  logic             ge;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] rem_nxt;

  // One trial subtraction per cycle
  always_comb begin
    trial   = {rem_r, lo_r[QUO_W-1]};
    den_x   = {1'b0, den_r};
    ge      = (trial >= den_x);
    diff    = trial - den_x;
    rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi;
      lo_r  <= lo;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* sv/triangle_tile_rasterizer_depth_test.sv */
// Top level: triangle setup, per-pixel tile walk, perspective weights and z-buffer test.
// Depends on ttrdt_pkg, ttrdt_in_if, ttrdt_out_if and ttrdt_div.
//
//   port     | dir | handshake      | moves
//   ---------+-----+----------------+----------------------------------------------
//   in_ch    | in  | valid/ready    | one request item: load vertex, tile, clear
//   out_ch   | out | valid/ready    | one fragment item per passing pixel
//   cfg_*    | in  | cfg_we only    | screen_width / screen_height register write
//
// A load is written in the cycle it is accepted. A tile runs the setup states MAP,
// AREA_MUL and AREA after the accepting cycle, then walks its pixels: a pixel outside
// the clamped box, outside the edges or with a zero perspective sum is skipped; one
// inside goes on through the weights and the depth test, and its five 17-bit quotients
// go through the single shared divider. ST_FLUSH ends the tile. Reset and a clear
// request sweep the depth memory one entry per cycle, all MAX_WIDTH*MAX_HEIGHT entries,
// with no item accepted. One passing fragment is held back so the last one can be
// marked; the walk stalls while the output register is full and the sink is not ready.
`timescale 1ns / 1ps

module triangle_tile_rasterizer_depth_test #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int TILE_SIZE  = 8,
  parameter int DEPTH_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ttrdt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ttrdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ttrdt_in_if.sink                         in_ch,
  ttrdt_out_if.source                      out_ch
);
  import ttrdt_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TW     = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [63:0] DMAX64 = 64'(DMAX);
  localparam logic signed [63:0] DMIN64 = -DMAX64 - 64'sd1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [CFG_DATA_W-1:0] scr_w_r, scr_h_r;
  logic [9:0]            w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= 10'd512;
      scr_h_r <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate dimensions to 1..MAX
  always_comb begin
    w_eff = scr_w_r;
    if (scr_w_r == 10'd0)
      w_eff = 10'd1;
    else if (32'(scr_w_r) > MAX_WIDTH)
      w_eff = 10'(MAX_WIDTH);
    h_eff = scr_h_r;
    if (scr_h_r == 10'd0)
      h_eff = 10'd1;
    else if (32'(scr_h_r) > MAX_HEIGHT)
      h_eff = 10'(MAX_HEIGHT);
  end

  // ---------------------------------------------------------------------------
  // Declarations
  st_t state_r, state_nxt;

  vtx_t vtx_r [NUM_SLOTS];

  logic signed [SW-1:0]  sx_r [NUM_SLOTS];
  logic signed [SW-1:0]  sy_r [NUM_SLOTS];
  logic [9:0]            wdim_r, hdim_r;
  logic signed [EW-1:0]  ar_p0_r, ar_p1_r, area_r;
  logic                  area_neg_r;
  logic signed [DFW-1:0] e1x_r, e1y_r, e2x_r, e2y_r;
  logic signed [SW-1:0]  xmn_r, xmx_r, ymn_r, ymx_r;
  logic signed [SW-1:0]  xlo_r, xhi_r, ylo_r, yhi_r;
  logic [5:0]            col_r, row_r;
  logic [TW-1:0]         tx_r, ty_r;
  logic signed [EW-1:0]  m0_r, m1_r, m2_r, m3_r;
  logic [EW-1:0]         eu_r, ev_r;
  logic [QUO_W-1:0]      bu_r, bv_r, wa_r, wb_r, wc_r;
  logic [PW-1:0]         pa_r, pb_r, pc_r;
  logic [SUMW-1:0]       s_r;
  logic signed [ZPW-1:0] zma_r, zmb_r, zmc_r;
  logic signed [DEPTH_BITS-1:0] z_r, rd_r;
  logic [ADDR_W-1:0]     clr_cnt_r;
  frag_t                 pend_r, out_r;
  logic                  pend_valid_r, out_valid_r;

  logic                  in_acc;
  logic                  out_free;

  // ---------------------------------------------------------------------------
  // Screen mapping of the three vertices
  logic signed [SW-1:0] sx_c [NUM_SLOTS];
  logic signed [SW-1:0] sy_c [NUM_SLOTS];

  always_comb begin
    logic signed [17:0] xo, yo;
    logic signed [28:0] px, py;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      xo = 18'(vtx_r[i].x) + 18'sd16384;
      yo = 18'sd16384 - 18'(vtx_r[i].y);
      px = xo * $signed({1'b0, w_eff});
      py = yo * $signed({1'b0, h_eff});
      sx_c[i] = SW'((px + 29'sd16384) >>> 7);
      sy_c[i] = SW'((py + 29'sd16384) >>> 7);
    end
  end

  // Area products, edge setup and raw bounding box
  logic signed [DFW-1:0] d10x, d10y, d20x, d20y;
  logic signed [EW-1:0]  ar_p0_c, ar_p1_c;
  logic signed [SW-1:0]  xmn_c, xmx_c, ymn_c, ymx_c;

  always_comb begin
    d10x    = DFW'(sx_r[1]) - DFW'(sx_r[0]);
    d10y    = DFW'(sy_r[1]) - DFW'(sy_r[0]);
    d20x    = DFW'(sx_r[2]) - DFW'(sx_r[0]);
    d20y    = DFW'(sy_r[2]) - DFW'(sy_r[0]);
    ar_p0_c = EW'(d10x) * EW'(d20y);
    ar_p1_c = EW'(d10y) * EW'(d20x);
    xmn_c = sx_r[0];
    xmx_c = sx_r[0];
    ymn_c = sy_r[0];
    ymx_c = sy_r[0];
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if (sx_r[i] < xmn_c) xmn_c = sx_r[i];
      if (sx_r[i] > xmx_c) xmx_c = sx_r[i];
      if (sy_r[i] < ymn_c) ymn_c = sy_r[i];
      if (sy_r[i] > ymx_c) ymx_c = sy_r[i];
    end
  end

  // Clamp the box to the screen (floor of min, ceil of max)
  logic signed [SW-1:0] xlo_c, xhi_c, ylo_c, yhi_c, wlim, hlim;

  always_comb begin
    wlim  = $signed({{(SW-10){1'b0}}, wdim_r}) - $signed(SW'(1));
    hlim  = $signed({{(SW-10){1'b0}}, hdim_r}) - $signed(SW'(1));
    xlo_c = xmn_r >>> 8;
    xhi_c = (xmx_r + $signed(SW'(255))) >>> 8;
    ylo_c = ymn_r >>> 8;
    yhi_c = (ymx_r + $signed(SW'(255))) >>> 8;
    if (xlo_c < 0) xlo_c = '0;
    if (ylo_c < 0) ylo_c = '0;
    if (xhi_c > wlim) xhi_c = wlim;
    if (yhi_c > hlim) yhi_c = hlim;
  end

  // ---------------------------------------------------------------------------
  // Current pixel and its edge products
  logic [8:0]            x_cur, y_cur;
  logic signed [SW-1:0]  xs, ys;
  logic                  in_box;
  logic signed [DFW-1:0] pxs, pys;
  logic signed [EW-1:0]  m0_c, m1_c, m2_c, m3_c;
  logic [ADDR_W-1:0]     pix_addr;

  always_comb begin
    x_cur  = 9'(col_r) * 9'(TILE_SIZE) + 9'(tx_r);
    y_cur  = 9'(row_r) * 9'(TILE_SIZE) + 9'(ty_r);
    xs     = $signed({{(SW-9){1'b0}}, x_cur});
    ys     = $signed({{(SW-9){1'b0}}, y_cur});
    in_box = (xs >= xlo_r) && (xs <= xhi_r) && (ys >= ylo_r) && (ys <= yhi_r);
    pxs    = $signed({{(DFW-17){1'b0}}, x_cur, 8'd0});
    pys    = $signed({{(DFW-17){1'b0}}, y_cur, 8'd0});
    m0_c   = EW'(e1x_r) * EW'(pys - DFW'(sy_r[1]));
    m1_c   = EW'(e1y_r) * EW'(pxs - DFW'(sx_r[1]));
    m2_c   = EW'(e2x_r) * EW'(pys - DFW'(sy_r[2]));
    m3_c   = EW'(e2y_r) * EW'(pxs - DFW'(sx_r[2]));
    pix_addr = ADDR_W'(y_cur) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_cur);
  end

  // Edge values, oriented so the area is positive
  logic signed [EW-1:0] eu_c, ev_c, ew_c;
  logic                 inside_c;

  always_comb begin
    eu_c = m0_r - m1_r;
    ev_c = m2_r - m3_r;
    ew_c = area_r - eu_c - ev_c;
    if (area_neg_r) begin
      eu_c = -eu_c;
      ev_c = -ev_c;
      ew_c = -ew_c;
    end
    inside_c = (eu_c >= 0) && (ev_c >= 0) && (ew_c >= 0);
  end

  // Perspective products and sum
  logic [QUO_W-1:0] bw_c;
  logic [SUMW-1:0]  s_c;

  always_comb begin
    bw_c = ONE_Q16 - bu_r - bv_r;
    s_c  = SUMW'(pa_r) + SUMW'(pb_r) + SUMW'(pc_r);
  end

  // Depth: round half up, saturate to the store width
  logic signed [ZSW-1:0] zsum_c, zsh_c;
  logic signed [63:0]    z64_c;

  always_comb begin
    zsum_c = ZSW'(zma_r) + ZSW'(zmb_r) + ZSW'(zmc_r) + $signed(ZSW'(32768));
    zsh_c  = zsum_c >>> 16;
    z64_c  = 64'(zsh_c);
    if (z64_c > DMAX64) z64_c = DMAX64;
    if (z64_c < DMIN64) z64_c = DMIN64;
  end

  // ---------------------------------------------------------------------------
  // Shared divider
  logic             div_start;
  logic [DIV_W-1:0] div_hi, div_den;
  logic [QUO_W-1:0] div_lo, div_q;
  div_sts_t         div_sts;

  ttrdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .den   (div_den),
    .quo   (div_q),
    .sts   (div_sts)
  );

  // ---------------------------------------------------------------------------
  // Next state
  logic tile_end;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign tile_end = (tx_r == TW'(TILE_SIZE - 1)) && (ty_r == TW'(TILE_SIZE - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == REQ_CLEAR)
            state_nxt = ST_CLEAR;
          else if (in_ch.req_type == REQ_RASTER)
            state_nxt = ST_MAP;
        end
      end
      ST_CLEAR:    if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_MAP:      state_nxt = ST_AREA_MUL;
      ST_AREA_MUL: state_nxt = ST_AREA;
      ST_AREA:     state_nxt = (ar_p0_r == ar_p1_r) ? ST_IDLE : ST_PIX;
      ST_PIX:      state_nxt = in_box ? ST_EDGE : ST_NEXT;
      ST_EDGE:     state_nxt = inside_c ? ST_BU_GO : ST_NEXT;
      ST_BU_GO:    state_nxt = ST_BU_WAIT;
      ST_BU_WAIT:  if (div_sts.done) state_nxt = ST_BV_GO;
      ST_BV_GO:    state_nxt = ST_BV_WAIT;
      ST_BV_WAIT:  if (div_sts.done) state_nxt = ST_SUM_MUL;
      ST_SUM_MUL:  state_nxt = ST_SUM;
      ST_SUM:      state_nxt = (s_c == '0) ? ST_NEXT : ST_WA_GO;
      ST_WA_GO:    state_nxt = ST_WA_WAIT;
      ST_WA_WAIT:  if (div_sts.done) state_nxt = ST_WB_GO;
      ST_WB_GO:    state_nxt = ST_WB_WAIT;
      ST_WB_WAIT:  if (div_sts.done) state_nxt = ST_WC_GO;
      ST_WC_GO:    state_nxt = ST_WC_WAIT;
      ST_WC_WAIT:  if (div_sts.done) state_nxt = ST_Z_MUL;
      ST_Z_MUL:    state_nxt = ST_Z;
      ST_Z:        state_nxt = ST_CMP;
      ST_CMP:      state_nxt = (z_r < rd_r) ? ST_EMIT : ST_NEXT;
      ST_EMIT:     if (!pend_valid_r || out_free) state_nxt = ST_NEXT;
      ST_NEXT:     state_nxt = tile_end ? ST_FLUSH : ST_PIX;
      ST_FLUSH:    if (!pend_valid_r || out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State outputs: handshake, divider operands, depth memory port
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_addr;
  logic signed [DEPTH_BITS-1:0] mem_wdata;
  logic                  out_load;

  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    div_hi      = DIV_W'(eu_r[EW-1:1]);
    div_lo      = {eu_r[0], {(QUO_W-1){1'b0}}};
    div_den     = DIV_W'(area_neg_r ? -area_r : area_r);
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = pix_addr;
    mem_wdata   = z_r;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = DMAX;
      end
      ST_BU_GO: div_start = 1'b1;
      ST_BV_GO: begin
        div_start = 1'b1;
        div_hi    = DIV_W'(ev_r[EW-1:1]);
        div_lo    = {ev_r[0], {(QUO_W-1){1'b0}}};
      end
      ST_WA_GO: begin
        div_start = 1'b1;
        div_hi    = DIV_W'(pa_r[PW-1:1]);
        div_lo    = {pa_r[0], {(QUO_W-1){1'b0}}};
        div_den   = DIV_W'(s_r);
      end
      ST_WB_GO: begin
        div_start = 1'b1;
        div_hi    = DIV_W'(pb_r[PW-1:1]);
        div_lo    = {pb_r[0], {(QUO_W-1){1'b0}}};
        div_den   = DIV_W'(s_r);
      end
      ST_WC_GO: begin
        div_start = 1'b1;
        div_hi    = DIV_W'(pc_r[PW-1:1]);
        div_lo    = {pc_r[0], {(QUO_W-1){1'b0}}};
        div_den   = DIV_W'(s_r);
      end
      ST_Z:     mem_re = 1'b1;
      ST_CMP:   mem_we = (z_r < rd_r);
      ST_EMIT:  out_load = pend_valid_r && out_free;
      ST_FLUSH: out_load = pend_valid_r && out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Depth memory, one read/write port, registered read
  logic signed [DEPTH_BITS-1:0] dstore [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we)
      dstore[mem_addr] <= mem_wdata;
    if (mem_re)
      rd_r <= dstore[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR)
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      else
        clr_cnt_r <= '0;
      if (state_r == ST_EMIT && (!pend_valid_r || out_free))
        pend_valid_r <= 1'b1;
      else if (state_r == ST_FLUSH && out_free)
        pend_valid_r <= 1'b0;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.req_type == REQ_LOAD && in_ch.vertex_slot < 2'(NUM_SLOTS))
          vtx_r[in_ch.vertex_slot] <= '{x: in_ch.ndc_x, y: in_ch.ndc_y,
                                        z: in_ch.ndc_z, rw: in_ch.recip_w};
        col_r <= in_ch.tile_col;
        row_r <= in_ch.tile_row;
      end
      ST_MAP: begin
        sx_r   <= sx_c;
        sy_r   <= sy_c;
        wdim_r <= w_eff;
        hdim_r <= h_eff;
      end
      ST_AREA_MUL: begin
        ar_p0_r <= ar_p0_c;
        ar_p1_r <= ar_p1_c;
        e1x_r   <= DFW'(sx_r[2]) - DFW'(sx_r[1]);
        e1y_r   <= DFW'(sy_r[2]) - DFW'(sy_r[1]);
        e2x_r   <= DFW'(sx_r[0]) - DFW'(sx_r[2]);
        e2y_r   <= DFW'(sy_r[0]) - DFW'(sy_r[2]);
        xmn_r   <= xmn_c;
        xmx_r   <= xmx_c;
        ymn_r   <= ymn_c;
        ymx_r   <= ymx_c;
      end
      ST_AREA: begin
        area_r     <= ar_p0_r - ar_p1_r;
        area_neg_r <= (ar_p0_r < ar_p1_r);
        xlo_r      <= xlo_c;
        xhi_r      <= xhi_c;
        ylo_r      <= ylo_c;
        yhi_r      <= yhi_c;
        tx_r       <= '0;
        ty_r       <= '0;
      end
      ST_PIX: begin
        m0_r <= m0_c;
        m1_r <= m1_c;
        m2_r <= m2_c;
        m3_r <= m3_c;
      end
      ST_EDGE: begin
        eu_r <= EW'(eu_c);
        ev_r <= EW'(ev_c);
      end
      ST_BU_WAIT: if (div_sts.done) bu_r <= div_q;
      ST_BV_WAIT: if (div_sts.done) bv_r <= div_q;
      ST_SUM_MUL: begin
        pa_r <= PW'(bu_r) * PW'(vtx_r[0].rw);
        pb_r <= PW'(bv_r) * PW'(vtx_r[1].rw);
        pc_r <= PW'(bw_c) * PW'(vtx_r[2].rw);
      end
      ST_SUM:     s_r <= s_c;
      ST_WA_WAIT: if (div_sts.done) wa_r <= div_q;
      ST_WB_WAIT: if (div_sts.done) wb_r <= div_q;
      ST_WC_WAIT: if (div_sts.done) wc_r <= div_q;
      ST_Z_MUL: begin
        zma_r <= vtx_r[0].z * $signed({1'b0, wa_r});
        zmb_r <= vtx_r[1].z * $signed({1'b0, wb_r});
        zmc_r <= vtx_r[2].z * $signed({1'b0, wc_r});
      end
      ST_Z: z_r <= DEPTH_BITS'(z64_c);
      ST_EMIT: begin
        if (!pend_valid_r || out_free)
          pend_r <= '{pixel_x: x_cur, pixel_y: y_cur, frag_depth: 24'(z_r),
                      weight_a: wa_r, weight_b: wb_r, weight_c: wc_r,
                      last_fragment: 1'b0};
      end
      ST_NEXT: begin
        if (tx_r == TW'(TILE_SIZE - 1)) begin
          tx_r <= '0;
          ty_r <= ty_r + TW'(1);
        end else begin
          tx_r <= tx_r + TW'(1);
        end
      end
      default: ;
    endcase
    // Output register: previous fragment, marked last when the tile is done
    if (out_load)
      out_r <= {pend_r[$bits(frag_t)-1:1], (state_r == ST_FLUSH)};
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_x       = out_r.pixel_x;
  assign out_ch.pixel_y       = out_r.pixel_y;
  assign out_ch.frag_depth    = out_r.frag_depth;
  assign out_ch.weight_a      = out_r.weight_a;
  assign out_ch.weight_b      = out_r.weight_b;
  assign out_ch.weight_c      = out_r.weight_c;
  assign out_ch.last_fragment = out_r.last_fragment;

  // ---------------------------------------------------------------------------
  // Assertions
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_no_pend_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pend_valid_r)
    else $error("held fragment left behind at end of tile");

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((19'(out_ch.weight_a) + 19'(out_ch.weight_b)
                       + 19'(out_ch.weight_c)) <= 19'd65536))
    else $error("perspective weights sum above one");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_CMP) |-> $past(mem_re))
    else $error("depth write without preceding read");

endmodule
